FILE: rtl/tsi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared widths, codes and types of the timestamp sync interpolator.
// ----------------------------------------------------------------------------
package tsi_pkg;

  localparam int unsigned TIME_W         = 32;
  localparam int unsigned FIELD_W        = 24;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned FIFO_DEPTH_DEF = 16;
  localparam int unsigned PROD_W         = FIELD_W + TIME_W + 1;
  localparam int unsigned NUM_W          = PROD_W + 1;
  localparam int unsigned QUOT_W         = FIELD_W;
  localparam logic [TIME_W-1:0] MAX_GAP_RST = 32'd5000;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_SYNC = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EARLY = 2'd1,
    ST_GAP   = 2'd2,
    ST_FEW   = 2'd3
  } status_e;

  typedef logic [1:0] axis_t;
  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0]         time_stamp;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } sample_t;

  typedef struct packed {
    logic    push;
    logic    latch_req;
    logic    drop;
    logic    copy_front;
    logic    mul0;
    logic    mul1;
    logic    mul2;
    logic    div_start;
    logic    store;
    logic    out_load;
    axis_t   ax;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_ge2;
    logic fill_ge3;
    logic t0_gt;
    logic t1_lt;
    logic gap_bad;
    logic times_eq;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [FIELD_W-1:0] pick_axis(sample_t s, axis_t ax);
    logic signed [FIELD_W-1:0] v;
    unique case (ax)
      AX_X:    v = s.x;
      AX_Y:    v = s.y;
      default: v = s.z;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tsi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsi interfaces
// Valid/ready channels for samples, results and the max_gap register.
// ----------------------------------------------------------------------------
interface tsi_in_if;
  import tsi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [TIME_W-1:0]         time_stamp;
  logic signed [FIELD_W-1:0] field_x;
  logic signed [FIELD_W-1:0] field_y;
  logic signed [FIELD_W-1:0] field_z;
  modport source (output valid, cmd, time_stamp, field_x, field_y, field_z, input ready);
  modport sink (input valid, cmd, time_stamp, field_x, field_y, field_z, output ready);
endinterface

interface tsi_out_if;
  import tsi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [TIME_W-1:0]         out_time;
  logic signed [FIELD_W-1:0] out_x;
  logic signed [FIELD_W-1:0] out_y;
  logic signed [FIELD_W-1:0] out_z;
  modport source (output valid, status, out_time, out_x, out_y, out_z, input ready);
  modport sink (input valid, status, out_time, out_x, out_y, out_z, output ready);
endinterface

interface tsi_cfg_if;
  import tsi_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tsi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsi_div
// Restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tsi_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [tsi_pkg::NUM_W-1:0]  num_i,
  input  wire logic [tsi_pkg::TIME_W-1:0]        den_i,
  output logic                                   done_o,
  output logic signed [tsi_pkg::QUOT_W-1:0]      quot_o
);
  import tsi_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic              run_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q;
  logic [TIME_W-1:0] rem_q;
  logic [TIME_W-1:0] den_q;
  logic [QUOT_W-1:0] sh_q;
  logic [NUM_W-1:0]  mag;
  logic [TIME_W:0]   rem2;
  logic [TIME_W:0]   diff;
  logic              ge;

  // |num| <= den * 2^23 < den * 2^24, so the upper part already lies below den
  assign mag  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign rem2 = {rem_q, sh_q[QUOT_W-1]};
  assign diff = rem2 - {1'b0, den_q};
  assign ge   = (rem2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CNT_W'(QUOT_W);
    end else if (run_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      rem_q <= mag[QUOT_W +: TIME_W];
      sh_q  <= mag[QUOT_W-1:0];
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[TIME_W-1:0] : rem2[TIME_W-1:0];
      sh_q  <= {sh_q[QUOT_W-2:0], ge};
    end
  end

  assign done_o = run_q && (cnt_q == CNT_W'(1));
  assign quot_o = neg_q ? QUOT_W'(-sh_q) : QUOT_W'(sh_q);

endmodule
`default_nettype wire

FILE: rtl/tsi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsi_ctrl
// Sequencer for push, drop loop, per-axis interpolation and result hand-off.
// ----------------------------------------------------------------------------
module tsi_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_cmd_i,
  output logic                    in_ready_o,
  input  wire tsi_pkg::dp_stat_t  stat_i,
  output tsi_pkg::ctrl_cmd_t      cmd_o
);
  import tsi_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_READ  = 10'b0000000010,
    S_EVAL  = 10'b0000000100,
    S_MUL0  = 10'b0000001000,
    S_MUL1  = 10'b0000010000,
    S_MUL2  = 10'b0000100000,
    S_DSTRT = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_STORE = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e  state_q, state_d;
  axis_t   ax_q, ax_d;
  status_e st_q, st_d;
  logic    accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    st_d    = st_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd_i == CMD_PUSH) begin
            cmd_o.push = 1'b1;
          end else begin
            cmd_o.latch_req = 1'b1;
            if (stat_i.fill_ge2) begin
              state_d = S_READ;
            end else begin
              st_d    = ST_FEW;
              state_d = S_FIN;
            end
          end
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        priority if (stat_i.t0_gt) begin
          st_d    = ST_EARLY;
          state_d = S_FIN;
        end else if (stat_i.t1_lt) begin
          cmd_o.drop = 1'b1;
          if (stat_i.fill_ge3) begin
            state_d = S_READ;
          end else begin
            st_d    = ST_FEW;
            state_d = S_FIN;
          end
        end else if (stat_i.gap_bad) begin
          cmd_o.drop = 1'b1;
          st_d       = ST_GAP;
          state_d    = S_FIN;
        end else if (stat_i.times_eq) begin
          cmd_o.copy_front = 1'b1;
          st_d             = ST_OK;
          state_d          = S_FIN;
        end else begin
          st_d    = ST_OK;
          ax_d    = AX_X;
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_DSTRT;
      end
      S_DSTRT: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_STORE;
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (ax_q == AX_Z) begin
          state_d = S_FIN;
        end else begin
          ax_d    = ax_q + axis_t'(1);
          state_d = S_MUL0;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.ax     = ax_q;
    cmd_o.status = st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ax_q    <= AX_X;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      st_q    <= st_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tsi_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsi_dp
// Sample FIFO memory, pointers, compares, shared multiplier and output register.
// ----------------------------------------------------------------------------
module tsi_dp #(
  parameter int unsigned FIFO_DEPTH = tsi_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tsi_pkg::ctrl_cmd_t                cmd_i,
  output tsi_pkg::dp_stat_t                      stat_o,
  input  wire logic [tsi_pkg::TIME_W-1:0]        in_time_i,
  input  wire logic signed [tsi_pkg::FIELD_W-1:0] in_x_i,
  input  wire logic signed [tsi_pkg::FIELD_W-1:0] in_y_i,
  input  wire logic signed [tsi_pkg::FIELD_W-1:0] in_z_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [tsi_pkg::TIME_W-1:0]        cfg_data_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [tsi_pkg::STATUS_W-1:0]           out_status_o,
  output logic [tsi_pkg::TIME_W-1:0]             out_time_o,
  output logic signed [tsi_pkg::FIELD_W-1:0]     out_x_o,
  output logic signed [tsi_pkg::FIELD_W-1:0]     out_y_o,
  output logic signed [tsi_pkg::FIELD_W-1:0]     out_z_o,
  output logic signed [tsi_pkg::NUM_W-1:0]       div_num_o,
  output logic [tsi_pkg::TIME_W-1:0]             div_den_o,
  input  wire logic                              div_done_i,
  input  wire logic signed [tsi_pkg::QUOT_W-1:0] div_quot_i
);
  import tsi_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  sample_t        mem_q [FIFO_DEPTH];
  sample_t        rd0_q, rd1_q, wdata;
  logic [AW-1:0]  head_q, head_nx, waddr;
  logic [CW-1:0]  fill_q;
  logic [SW-1:0]  tail_sum;
  logic           full;
  logic [TIME_W-1:0] req_q, max_gap_q;
  logic [TIME_W-1:0] d_hi, d_lo;

  logic signed [FIELD_W-1:0] mul_a;
  logic signed [TIME_W:0]    mul_b;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [NUM_W-1:0]   acc_q;
  logic signed [FIELD_W-1:0] res_x_q, res_y_q, res_z_q;
  logic                      out_valid_q;

  // fifo pointers
  assign head_nx  = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign full     = (fill_q == CW'(FIFO_DEPTH));
  assign tail_sum = SW'(head_q) + SW'(fill_q);
  assign waddr    = full ? head_q
                  : (tail_sum >= SW'(FIFO_DEPTH)) ? AW'(tail_sum - SW'(FIFO_DEPTH))
                  : AW'(tail_sum);
  assign wdata    = '{time_stamp: in_time_i, x: in_x_i, y: in_y_i, z: in_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.push) begin
      if (full) head_q <= head_nx;
      else      fill_q <= fill_q + CW'(1);
    end else if (cmd_i.drop) begin
      head_q <= head_nx;
      fill_q <= fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem_q[waddr] <= wdata;
    rd0_q <= mem_q[head_q];
    rd1_q <= mem_q[head_nx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_gap_q <= MAX_GAP_RST;
    else if (cfg_we_i) max_gap_q <= cfg_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) req_q <= in_time_i;
  end

  // distances only meaningful once t0 <= req <= t1
  assign d_lo = req_q - rd0_q.time_stamp;
  assign d_hi = rd1_q.time_stamp - req_q;

  assign stat_o.fill_ge2 = (fill_q >= CW'(2));
  assign stat_o.fill_ge3 = (fill_q >= CW'(3));
  assign stat_o.t0_gt    = (rd0_q.time_stamp > req_q);
  assign stat_o.t1_lt    = (rd1_q.time_stamp < req_q);
  assign stat_o.gap_bad  = (d_lo > max_gap_q) || (d_hi > max_gap_q);
  assign stat_o.times_eq = (rd0_q.time_stamp == rd1_q.time_stamp);
  assign stat_o.div_done = div_done_i;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // shared multiplier: front * (t1 - req), then back * (req - t0)
  assign mul_a = cmd_i.mul0 ? pick_axis(rd0_q, cmd_i.ax) : pick_axis(rd1_q, cmd_i.ax);
  assign mul_b = cmd_i.mul0 ? $signed({1'b0, d_hi}) : $signed({1'b0, d_lo});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul0 || cmd_i.mul1) prod_q <= PROD_W'(mul_a * mul_b);
    if (cmd_i.mul1) acc_q <= NUM_W'(prod_q);
    else if (cmd_i.mul2) acc_q <= acc_q + NUM_W'(prod_q);
  end

  assign div_num_o = acc_q;
  assign div_den_o = rd1_q.time_stamp - rd0_q.time_stamp;

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_front) begin
      res_x_q <= rd0_q.x;
      res_y_q <= rd0_q.y;
      res_z_q <= rd0_q.z;
    end else if (cmd_i.store) begin
      unique case (cmd_i.ax)
        AX_X:    res_x_q <= div_quot_i;
        AX_Y:    res_y_q <= div_quot_i;
        default: res_z_q <= div_quot_i;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_o <= cmd_i.status;
      out_time_o   <= req_q;
      out_x_o      <= (cmd_i.status == ST_OK) ? res_x_q : '0;
      out_y_o      <= (cmd_i.status == ST_OK) ? res_y_q : '0;
      out_z_o      <= (cmd_i.status == ST_OK) ? res_z_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/timestamp_sync_interpolator.sv
// steps: a push is stored and the input stays ready; a sync request drops samples while
//   scanning, then ends at a compare (early, gap or equal times), when too few samples
//   are left, or interpolates (per axis the multiply states MUL0 to MUL2, a divider
//   start, 24 divider steps and a store)
// throughput: one item at a time; the input is ready again only once a request is done
// reset: fifo empty, max_gap 5000; sample storage is not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_sync_interpolator
// Timestamped magnetometer sample fifo with linear interpolation on request.
// ----------------------------------------------------------------------------
module timestamp_sync_interpolator #(
  parameter int unsigned FIFO_DEPTH = tsi_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tsi_in_if.sink     in_i,
  tsi_out_if.source  out_o,
  tsi_cfg_if.sink    cfg_i
);
  import tsi_pkg::*;

  ctrl_cmd_t                 cmd;
  dp_stat_t                  stat;
  logic signed [NUM_W-1:0]   div_num;
  logic [TIME_W-1:0]         div_den;
  logic                      div_done;
  logic signed [QUOT_W-1:0]  div_quot;

  assign cfg_i.ready = 1'b1;

  tsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tsi_dp #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_time_i    (in_i.time_stamp),
    .in_x_i       (in_i.field_x),
    .in_y_i       (in_i.field_y),
    .in_z_i       (in_i.field_z),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_time_o   (out_o.out_time),
    .out_x_o      (out_o.out_x),
    .out_y_o      (out_o.out_y),
    .out_z_o      (out_o.out_z),
    .div_num_o    (div_num),
    .div_den_o    (div_den),
    .div_done_i   (div_done),
    .div_quot_i   (div_quot)
  );

  tsi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

endmodule
`default_nettype wire

FILE: rtl/tsi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsi_checker
// Port-level checks of the timestamp sync interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module tsi_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               in_cmd,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [tsi_pkg::STATUS_W-1:0]       out_status,
  input wire logic signed [tsi_pkg::FIELD_W-1:0] out_x,
  input wire logic signed [tsi_pkg::FIELD_W-1:0] out_y,
  input wire logic signed [tsi_pkg::FIELD_W-1:0] out_z
);
  import tsi_pkg::*;

  // result item waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before taken");

  // failed requests carry zero fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status != ST_OK) |-> (out_x == '0) && (out_y == '0) && (out_z == '0))
    else $error("failed request with nonzero fields");

  // a sync request keeps the input side busy
  a_sync_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_cmd == CMD_SYNC) |=> !in_ready)
    else $error("input ready right after a sync request");

  // a push leaves the input ready for the next item
  a_push_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_cmd == CMD_PUSH) |=> in_ready)
    else $error("input not ready after a push");

endmodule

bind timestamp_sync_interpolator tsi_checker u_tsi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .in_cmd     (in_i.cmd),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_status (out_o.status),
  .out_x      (out_o.out_x),
  .out_y      (out_o.out_y),
  .out_z      (out_o.out_z)
);
`default_nettype wire
